// File: hdl/lms_pkg.sv
// shared types and constants for the led matrix scroll scanner
`timescale 1ns / 1ps

package lms_pkg;

  // line store size unless the top level is told otherwise
  localparam int BUFFER_DEPTH_DEFAULT = 64;

  // zero columns shown before the line in scroll mode
  localparam logic [7:0] PAD_COLUMNS = 8'd8;
  // extra positions past the line length before the offset wraps
  localparam logic [7:0] WRAP_EXTRA  = 8'd7;
  // saturation point of the scroll tick counter
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  // request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SCROLL_MODE        = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_LENGTH        = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCROLL_PERIOD      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS_ACTIVE_LOW = 2'd3;

  // reset value of the scroll period register
  localparam logic [15:0] SCROLL_PERIOD_RESET = 16'd100;

  // input beat
  typedef struct packed {
    logic       req_type;
    logic [5:0] load_index;
    logic [7:0] load_data;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [7:0] row_bits;
    logic [2:0] column_index;
    logic [7:0] column_drive;
    logic [6:0] scroll_position;
  } out_beat_t;

  // per-tick information that travels alongside the store read
  typedef struct packed {
    logic       blank;
    logic [2:0] column_index;
    logic [7:0] column_drive;
    logic [6:0] scroll_position;
  } scan_info_t;

endpackage

// File: hdl/lms_line_store.sv
// line buffer memory with one write port and one registered read port
`timescale 1ns / 1ps

module lms_line_store import lms_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [5:0]                      wr_index,
  input  logic [7:0]                      wr_data,
  input  logic                            rd_en,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr,
  output logic [7:0]                      rd_data
);

  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam logic [8:0] DEPTH_LIMIT = 9'(BUFFER_DEPTH);

  logic [7:0]        mem [BUFFER_DEPTH];
  logic [8:0]        wr_index_wide;
  logic              wr_in_range;
  logic [ADDR_W-1:0] wr_addr;

  // loads beyond the store are dropped
  assign wr_index_wide = {3'b000, wr_index};
  assign wr_in_range   = wr_index_wide < DEPTH_LIMIT;
  assign wr_addr       = wr_index_wide[ADDR_W-1:0];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/lms_scan_ctrl.sv
// configuration registers, column and scroll state, and read address generation
`timescale 1ns / 1ps

module lms_scan_ctrl import lms_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [CFG_INDEX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]           cfg_data,
  input  logic                            step,
  output logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr,
  output scan_info_t                      info
);

  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam logic [8:0] DEPTH_LIMIT = 9'(BUFFER_DEPTH);
  localparam logic [6:0] DEPTH_LEN   = (BUFFER_DEPTH > 127) ? 7'd127 : 7'(BUFFER_DEPTH);

  // configuration
  logic        scroll_mode;
  logic [6:0]  line_length;
  logic [15:0] scroll_period;
  logic        columns_active_low;

  // scan state
  logic [2:0]  column_counter;
  logic [6:0]  scroll_offset;
  logic [15:0] tick_count;

  logic [2:0]  column_counter_next;
  logic [6:0]  scroll_offset_next;
  logic [15:0] tick_count_next;

  logic [6:0]  eff_length;
  logic [15:0] count_inc;
  logic        wrapped;
  logic        advance;
  logic [7:0]  offset_inc;
  logic [7:0]  wrap_point;
  logic [7:0]  virt_pos;
  logic [7:0]  line_pos;
  logic        scroll_blank;
  logic [7:0]  sel_pos;
  logic [8:0]  sel_pos_wide;
  logic [7:0]  one_hot;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_mode        <= 1'b0;
      line_length        <= 7'd0;
      scroll_period      <= SCROLL_PERIOD_RESET;
      columns_active_low <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SCROLL_MODE:        scroll_mode        <= cfg_data[0];
        CFG_LINE_LENGTH:        line_length        <= cfg_data[6:0];
        CFG_SCROLL_PERIOD:      scroll_period      <= cfg_data[15:0];
        CFG_COLUMNS_ACTIVE_LOW: columns_active_low <= cfg_data[0];
      endcase
    end
  end

  // line length clipped to the store size
  assign eff_length = ({2'b00, line_length} > DEPTH_LIMIT) ? DEPTH_LEN : line_length;

  // column, tick count and scroll offset update for one tick
  always_comb begin
    column_counter_next = column_counter + 3'd1;
    wrapped             = column_counter_next == 3'd0;
    count_inc           = (scroll_mode && tick_count != COUNT_MAX) ? tick_count + 16'd1
                                                                   : tick_count;
    advance             = wrapped && scroll_mode && (count_inc >= scroll_period);
    offset_inc          = {1'b0, scroll_offset} + 8'd1;
    wrap_point          = {1'b0, eff_length} + WRAP_EXTRA;
    scroll_offset_next  = scroll_offset;
    tick_count_next     = count_inc;
    if (advance) begin
      scroll_offset_next = (offset_inc >= wrap_point) ? 7'd0 : offset_inc[6:0];
      tick_count_next    = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= 3'd0;
      scroll_offset  <= 7'd0;
      tick_count     <= 16'd0;
    end else if (step) begin
      column_counter <= column_counter_next;
      scroll_offset  <= scroll_offset_next;
      tick_count     <= tick_count_next;
    end
  end

  // position in the padded line and whether it falls in the padding
  always_comb begin
    virt_pos     = {1'b0, scroll_offset_next} + {5'b00000, column_counter_next};
    line_pos     = virt_pos - PAD_COLUMNS;
    scroll_blank = (virt_pos < PAD_COLUMNS) || (line_pos >= {1'b0, eff_length});
    sel_pos      = scroll_mode ? line_pos : {5'b00000, column_counter_next};
    sel_pos_wide = {1'b0, sel_pos};
  end

  assign rd_addr = sel_pos_wide[ADDR_W-1:0];

  // column drive pattern
  assign one_hot = 8'b0000_0001 << column_counter_next;

  always_comb begin
    info.blank           = scroll_mode && scroll_blank;
    info.column_index    = column_counter_next;
    info.column_drive    = one_hot ^ {8{columns_active_low}};
    info.scroll_position = scroll_offset_next;
  end

endmodule

// File: hdl/led_matrix_scroll_scanner_core.sv
// top level of the led matrix scroll scanner
`timescale 1ns / 1ps

// Column scanner for an 8x8 LED matrix, static or scrolling.
// Input channel (in_valid, in_stall, in_data): a load beat writes one column
// byte into the line store and gives no result; a tick beat steps the column
// counter and gives exactly one result beat.
// Output channel (out_valid, out_stall, out_data): row pattern, column index,
// column drive pattern and scroll position for each tick.
// Configuration (cfg_write, cfg_index, cfg_data): 0 scroll mode, 1 line length,
// 2 scroll period, 3 columns active low; write only while the block is idle.
// out_valid rises when the read stage moves into the output register; the store
// read register loads at the accepting edge and the output register when the
// read stage moves on. Throughput: one beat per cycle while in_stall is low,
// set by the store read port. A result waiting under out_stall does not block
// the next tick: the read stage holds one more, and only then is in_stall raised.
// Reset clears the column counter, scroll offset, tick count and all valid
// flags, and returns the configuration to its reset values; line store
// contents are undefined until loaded.

module led_matrix_scroll_scanner_core import lms_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_beat_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_beat_t              out_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int ADDR_W = $clog2(BUFFER_DEPTH);

  logic              in_accept;
  logic              tick_accept;
  logic              load_accept;
  logic              s1_valid;
  logic              s1_move;
  scan_info_t        s1_info;
  scan_info_t        info;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  // handshake
  assign s1_move     = s1_valid && (!out_valid || !out_stall);
  assign in_stall    = s1_valid && !s1_move;
  assign in_accept   = in_valid && !in_stall;
  assign tick_accept = in_accept && (in_data.req_type == REQ_TICK);
  assign load_accept = in_accept && (in_data.req_type == REQ_LOAD);

  // scan state and address generation
  lms_scan_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (tick_accept),
    .rd_addr   (rd_addr),
    .info      (info)
  );

  // line buffer
  lms_line_store #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk      (clk),
    .wr_en    (load_accept),
    .wr_index (in_data.load_index),
    .wr_data  (in_data.load_data),
    .rd_en    (tick_accept),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  // read stage, alongside the store read register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_accept) begin
      s1_info <= info;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data.row_bits        <= s1_info.blank ? 8'd0 : rd_data;
      out_data.column_index    <= s1_info.column_index;
      out_data.column_drive    <= s1_info.column_drive;
      out_data.scroll_position <= s1_info.scroll_position;
    end
  end

endmodule
